/* hdl/rtsm_pkg.sv */
// Package for the RC throttle and steering mapper: widths, constants, span reciprocals,
// the queued item type and the back-end state type. No dependencies.
package rtsm_pkg;

  localparam int CHAN_W = 11;
  localparam int DIST_W = 11;
  localparam int DIV_STEPS = 15;
  localparam int MAG_W = DIV_STEPS + 1;
  localparam int PADDR_W = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CHAN_W-1:0] THR_HI_EDGE = 11'd1010;
  localparam logic [CHAN_W-1:0] THR_LO_EDGE = 11'd970;
  localparam logic [DIST_W-1:0] THR_HI_SPAN = 11'd690;
  localparam logic [DIST_W-1:0] THR_LO_SPAN = 11'd620;
  localparam logic [CHAN_W-1:0] STR_LO_EDGE = 11'd1200;
  localparam logic [CHAN_W-1:0] STR_HI_EDGE = 11'd1260;
  localparam logic [DIST_W-1:0] STR_LO_SPAN = 11'd790;
  localparam logic [DIST_W-1:0] STR_HI_SPAN = 11'd551;

  // Ceiling reciprocals of the spans scaled by 2^35. For a distance below the span the
  // rounded numerator times the span stays under 2^35, so the product shifted down by
  // 35 is the exact quotient.
  localparam int RECIP_SH = 35;
  localparam int RECIP_W = 26;
  localparam int NUMER_W = DIST_W + DIV_STEPS;
  localparam logic [RECIP_W-1:0] THR_HI_RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(THR_HI_SPAN) - 64'd1) / 64'(THR_HI_SPAN));
  localparam logic [RECIP_W-1:0] THR_LO_RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(THR_LO_SPAN) - 64'd1) / 64'(THR_LO_SPAN));
  localparam logic [RECIP_W-1:0] STR_LO_RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(STR_LO_SPAN) - 64'd1) / 64'(STR_LO_SPAN));
  localparam logic [RECIP_W-1:0] STR_HI_RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(STR_HI_SPAN) - 64'd1) / 64'(STR_HI_SPAN));

  localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(1) << DIV_STEPS;
  localparam logic signed [23:0] SNAP_Q23 = 24'sd587203;

  localparam logic [31:0] ZERO_OFFSET_RST = 32'd0;
  localparam logic [30:0] MAX_OFFSET_RST = 31'd65536;
  localparam logic [15:0] ALPHA_RST = 16'd6554;

  localparam logic [1:0] REG_ZERO_OFFSET = 2'd0;
  localparam logic [1:0] REG_MAX_OFFSET = 2'd1;
  localparam logic [1:0] REG_ALPHA = 2'd2;

  typedef enum logic [1:0] {
    SIDE_ZERO,
    SIDE_POS,
    SIDE_NEG
  } side_t;

  typedef struct packed {
    logic              frame_valid;
    side_t             thr_side;
    logic [DIST_W-1:0] thr_dist;
    side_t             str_side;
    logic [DIST_W-1:0] str_dist;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PRODUCT,
    ST_UPDATE,
    ST_WRITE
  } back_state_t;

endpackage

/* hdl/rtsm_front.sv */
// Front end: classifies one frame into deadband sides and distances from the edges.
// Depends on rtsm_pkg.
module rtsm_front
  import rtsm_pkg::*;
(
  input  logic              frame_valid,
  input  logic [CHAN_W-1:0] throttle_channel,
  input  logic [CHAN_W-1:0] steer_channel,
  output item_t             item
);

  always_comb begin
    item.frame_valid = frame_valid;
    if (throttle_channel > THR_HI_EDGE) begin
      item.thr_side = SIDE_POS;
      item.thr_dist = throttle_channel - THR_HI_EDGE;
    end else if (throttle_channel < THR_LO_EDGE) begin
      item.thr_side = SIDE_NEG;
      item.thr_dist = THR_LO_EDGE - throttle_channel;
    end else begin
      item.thr_side = SIDE_ZERO;
      item.thr_dist = '0;
    end
    if (steer_channel < STR_LO_EDGE) begin
      item.str_side = SIDE_NEG;
      item.str_dist = STR_LO_EDGE - steer_channel;
    end else if (steer_channel > STR_HI_EDGE) begin
      item.str_side = SIDE_POS;
      item.str_dist = steer_channel - STR_HI_EDGE;
    end else begin
      item.str_side = SIDE_ZERO;
      item.str_dist = '0;
    end
  end

endmodule

/* hdl/rtsm_queue.sv */
// Short FIFO of classified items between the front and back ends.
// Depends on rtsm_pkg for the item type.
module rtsm_queue
  import rtsm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/rtsm_div.sv */
// Fractional divider by reciprocal multiplication: round(delta * 2^15 / span), saturated
// at one, with the operands and then the product registered after start. Depends on rtsm_pkg.
module rtsm_div
  import rtsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIST_W-1:0]  delta,
  input  logic [DIST_W-1:0]  span,
  input  logic [RECIP_W-1:0] recip,
  output logic               done,
  output logic [MAG_W-1:0]   mag
);

  logic                       busy;
  logic [NUMER_W-1:0]         numer;
  logic [RECIP_W-1:0]         recip_q;
  logic                       sat;
  logic [NUMER_W+RECIP_W-1:0] prod;

  assign done = !busy;
  assign mag  = sat ? MAG_ONE : prod[RECIP_SH +: MAG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  // Half the span is added first so the truncated quotient rounds to nearest.
  always_ff @(posedge clk) begin
    if (start) begin
      numer   <= {delta, {DIV_STEPS{1'b0}}} + NUMER_W'(span >> 1);
      recip_q <= recip;
      sat     <= (delta >= span);
    end
    if (busy) begin
      prod <= numer * recip_q;
    end
  end

endmodule

/* hdl/rtsm_back.sv */
// Back end: divides, filters the duty, builds the steering target and holds the result.
// Depends on rtsm_pkg and rtsm_div.
module rtsm_back
  import rtsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  item_t               q_item,
  output logic                q_pop,
  input  logic signed [31:0]  zero_offset,
  input  logic [30:0]         max_offset,
  input  logic [15:0]         alpha,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  duty_cmd,
  output logic                duty_updated,
  output logic signed [31:0]  steer_target
);

  back_state_t state;
  back_state_t state_next;

  item_t              entry;
  logic signed [16:0] duty;
  logic [MAG_W-1:0]   smag;
  logic signed [42:0] prod_f;
  logic [46:0]        prod_s;
  logic signed [23:0] duty_filter;
  logic signed [31:0] last_target;

  logic               div_start;
  logic               out_load;
  logic               thr_done;
  logic               str_done;
  logic [MAG_W-1:0]   thr_mag;
  logic [MAG_W-1:0]   str_mag;
  logic [DIST_W-1:0]  thr_span;
  logic [DIST_W-1:0]  str_span;
  logic [RECIP_W-1:0] thr_recip;
  logic [RECIP_W-1:0] str_recip;

  assign thr_span  = (q_item.thr_side == SIDE_POS) ? THR_HI_SPAN : THR_LO_SPAN;
  assign str_span  = (q_item.str_side == SIDE_POS) ? STR_HI_SPAN : STR_LO_SPAN;
  assign thr_recip = (q_item.thr_side == SIDE_POS) ? THR_HI_RECIP : THR_LO_RECIP;
  assign str_recip = (q_item.str_side == SIDE_POS) ? STR_HI_RECIP : STR_LO_RECIP;

  rtsm_div u_thr_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .delta (q_item.thr_dist),
    .span  (thr_span),
    .recip (thr_recip),
    .done  (thr_done),
    .mag   (thr_mag)
  );

  rtsm_div u_str_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .delta (q_item.str_dist),
    .span  (str_span),
    .recip (str_recip),
    .done  (str_done),
    .mag   (str_mag)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = q_item.frame_valid ? ST_DIVIDE : ST_WRITE;
        end
      end
      ST_DIVIDE: begin
        if (thr_done && str_done) begin
          state_next = ST_PRODUCT;
        end
      end
      ST_PRODUCT: state_next = ST_UPDATE;
      ST_UPDATE:  state_next = ST_WRITE;
      ST_WRITE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop     = !q_empty;
        div_start = !q_empty && q_item.frame_valid;
      end
      ST_WRITE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Signed duty from the throttle magnitude; the positive side tops out at 32767.
  logic signed [16:0] duty_new;
  always_comb begin
    case (entry.thr_side)
      SIDE_POS: begin
        duty_new = thr_mag[MAG_W-1] ? 17'sd32767 : $signed({1'b0, thr_mag});
      end
      SIDE_NEG: duty_new = -$signed({1'b0, thr_mag});
      default:  duty_new = '0;
    endcase
  end

  logic signed [25:0] diff;
  assign diff = $signed({duty[16], duty, 8'b0}) - $signed({{2{duty_filter[23]}}, duty_filter});

  always_ff @(posedge clk) begin
    if (q_pop) begin
      entry <= q_item;
    end
    if (state == ST_DIVIDE) begin
      duty <= duty_new;
      smag <= str_mag;
    end
    if (state == ST_PRODUCT) begin
      prod_f <= $signed({1'b0, alpha}) * diff;
      prod_s <= smag * max_offset;
    end
  end

  // Filter update: add the rounded weighted step, clamp to Q1.23, snap small values.
  logic signed [42:0] rnd_f;
  logic signed [26:0] step_f;
  logic signed [27:0] sum_f;
  logic signed [23:0] clamp_f;
  logic signed [23:0] filt_new;
  always_comb begin
    rnd_f  = prod_f + 43'sd32768;
    step_f = rnd_f[42:16];
    sum_f  = $signed({{4{duty_filter[23]}}, duty_filter}) + $signed({step_f[26], step_f});
    if (sum_f[27:23] == 5'b00000 || sum_f[27:23] == 5'b11111) begin
      clamp_f = sum_f[23:0];
    end else begin
      clamp_f = sum_f[27] ? 24'sh800000 : 24'sh7FFFFF;
    end
    filt_new = (clamp_f > -SNAP_Q23 && clamp_f < SNAP_Q23) ? '0 : clamp_f;
  end

  // Steering target: rounded offset added to or taken from the centre, saturated.
  logic [47:0]        rnd_s;
  logic [31:0]        off;
  logic signed [33:0] sum_s;
  logic signed [31:0] target_new;
  always_comb begin
    rnd_s = {1'b0, prod_s} + 48'd16384;
    off   = rnd_s[46:15];
    if (entry.str_side == SIDE_NEG) begin
      sum_s = $signed({{2{zero_offset[31]}}, zero_offset}) - $signed({2'b00, off});
    end else begin
      sum_s = $signed({{2{zero_offset[31]}}, zero_offset}) + $signed({2'b00, off});
    end
    if (sum_s[33:31] == 3'b000 || sum_s[33:31] == 3'b111) begin
      target_new = sum_s[31:0];
    end else begin
      target_new = sum_s[33] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_filter <= '0;
      last_target <= '0;
    end else if (state == ST_UPDATE) begin
      duty_filter <= filt_new;
      last_target <= target_new;
    end
  end

  // Q1.23 to Q1.15 with halves toward plus infinity; only +1.0 can overflow.
  logic signed [24:0] cmd_rnd;
  logic signed [15:0] cmd_new;
  always_comb begin
    cmd_rnd = $signed({duty_filter[23], duty_filter}) + 25'sd128;
    cmd_new = (!cmd_rnd[24] && cmd_rnd[23]) ? 16'sd32767 : cmd_rnd[23:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      duty_cmd     <= cmd_new;
      duty_updated <= entry.frame_valid;
      steer_target <= last_target;
    end
  end

endmodule

/* hdl/rc_throttle_steer_mapper.sv */
// Top level of the RC throttle and steering mapper: register port, front end,
// item queue and back end. Depends on rtsm_pkg, rtsm_front, rtsm_queue and rtsm_back.
//
//   Channel   Handshake            Payload
//   in        in_valid/in_ready    frame_valid, throttle_channel, steer_channel
//   out       out_valid/out_ready  duty_cmd, duty_updated, steer_target
//   config    APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// A valid frame goes through the back end in order: it is pulled from the queue, the
// reciprocal dividers run side by side (operand load, then a registered product), the
// filter and steering multipliers run, the state is updated and the output register
// is loaded. An invalid frame is pulled and loaded, since it only repeats held values.
// Reset is synchronous and returns the registers to their defaults, the filter and the
// held steering target to zero, and empties the queue. The front end keeps taking items
// while the queue has room, and the back end stalls only when the output register is
// still full.
module rc_throttle_steer_mapper
  import rtsm_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               frame_valid,
  input  logic [CHAN_W-1:0]  throttle_channel,
  input  logic [CHAN_W-1:0]  steer_channel,
  // Result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] duty_cmd,
  output logic               duty_updated,
  output logic signed [31:0] steer_target
);

  logic signed [31:0] steer_zero_offset;
  logic [30:0]        steer_max_offset;
  logic [15:0]        smoothing_alpha;
  logic               cfg_write;
  logic [1:0]         reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Writes to an address past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      steer_zero_offset <= ZERO_OFFSET_RST;
      steer_max_offset  <= MAX_OFFSET_RST;
      smoothing_alpha   <= ALPHA_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_ZERO_OFFSET: steer_zero_offset <= pwdata;
        REG_MAX_OFFSET:  steer_max_offset  <= pwdata[30:0];
        REG_ALPHA:       smoothing_alpha   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_ZERO_OFFSET: prdata = steer_zero_offset;
      REG_MAX_OFFSET:  prdata = {1'b0, steer_max_offset};
      REG_ALPHA:       prdata = {16'd0, smoothing_alpha};
      default:         prdata = '0;
    endcase
  end

  // The front end classifies each accepted frame so the queue carries only what
  // the back end needs: validity, deadband side and distance for each channel.
  item_t front_item;
  item_t back_item;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  rtsm_front u_front (
    .frame_valid      (frame_valid),
    .throttle_channel (throttle_channel),
    .steer_channel    (steer_channel),
    .item             (front_item)
  );

  assign in_ready = !q_full;

  rtsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (back_item),
    .empty     (q_empty)
  );

  // The back end works on one item at a time, since the next duty depends on the
  // filter value this one leaves behind.
  rtsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_item       (back_item),
    .q_pop        (q_pop),
    .zero_offset  (steer_zero_offset),
    .max_offset   (steer_max_offset),
    .alpha        (smoothing_alpha),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .duty_cmd     (duty_cmd),
    .duty_updated (duty_updated),
    .steer_target (steer_target)
  );

endmodule
